// ===== hw/rtl/sep_pkg.sv =====
package sep_pkg;

  localparam int DEF_RAMP_FRAMES = 64;
  localparam int DEF_SAMPLE_BITS = 24;
  localparam int DEF_MAX_BLOCK   = 8192;

  localparam int NUM_PATHS  = 4;
  localparam int G_W        = 18;
  localparam int DES_W      = 17;
  localparam int COEF_W     = 29;
  localparam int DIV_W      = 19;
  localparam int DIV_CNT_W  = $clog2(DIV_W);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;
  localparam int FPB_W      = 14;

  localparam logic [15:0]      PAN_K       = 16'd54512;
  localparam logic [16:0]      PAN_A       = 17'd120048;
  localparam logic [14:0]      SMOOTH_Q15  = 15'd29491;
  localparam logic [DIV_W-1:0] NEAR_LIMIT  = DIV_W'(65);
  localparam logic [DES_W-1:0] UNITY_Q15   = 17'd32768;
  localparam logic [G_W-1:0]   G_MAX       = 18'h1FFFF;
  localparam logic [G_W-1:0]   G_MIN       = 18'h20000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAN    = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_GAIN   = 2'd2,
    REG_FRAMES = 2'd3
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TGT_POS,
    ST_TGT_SQ,
    ST_TGT_MUL,
    ST_TGT_FIN,
    ST_CHECK,
    ST_DIV,
    ST_DIV_FIN,
    ST_RAMP_ADD,
    ST_RAMP_MUL,
    ST_RAMP_UPD,
    ST_COEF,
    ST_PROD,
    ST_MERGE
  } state_e;

  typedef struct packed {
    logic tgt_sq;
    logic tgt_mul;
    logic tgt_fin;
    logic check;
    logic div_step;
    logic div_fin;
    logic ramp_add;
    logic ramp_mul;
    logic ramp_upd;
    logic coef;
    logic prod;
  } lane_ctrl_t;

  function automatic logic [G_W-1:0] sat18(input logic [20:0] v);
    logic fits;
    fits = (&v[20:17]) | ~(|v[20:17]);
    if (fits) begin
      return v[17:0];
    end else if (v[20]) begin
      return G_MIN;
    end else begin
      return G_MAX;
    end
  endfunction

  function automatic logic [15:0] clamp_lane(input logic [17:0] v);
    if (v[17]) begin
      return 16'd0;
    end else if (v > 18'd32768) begin
      return 16'd32768;
    end else begin
      return v[15:0];
    end
  endfunction

endpackage

// ===== hw/rtl/sep_lane.sv =====
module sep_lane #(
  parameter int SAMPLE_BITS = sep_pkg::DEF_SAMPLE_BITS,
  parameter int LIM_W       = $clog2(sep_pkg::DEF_RAMP_FRAMES + 1),
  parameter bit IS_DIAG     = 1'b0
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  sep_pkg::lane_ctrl_t                         ctrl_i,
  input  logic [15:0]                                 x_i,
  input  logic [15:0]                                 master_i,
  input  logic [LIM_W-1:0]                            lim_i,
  input  logic signed [SAMPLE_BITS-1:0]               sample_i,
  output logic signed [SAMPLE_BITS+sep_pkg::COEF_W-1:0] prod_o
);
  import sep_pkg::*;

  localparam int PW = SAMPLE_BITS + COEF_W;
  localparam logic [DES_W-1:0] RST_GAIN = IS_DIAG ? UNITY_Q15 : '0;

  logic [G_W-1:0]   cur_q, ramp_q, step_q;
  logic [DES_W-1:0] desired_q;
  logic             far_q, dpos_q;
  logic [DIV_W-1:0] dq_q;
  logic [LIM_W-1:0] dr_q;

  logic [30:0]      sq_q;
  logic [31:0]      ax_q;
  logic [45:0]      bq_q;
  logic signed [34:0] sm_q;
  logic [COEF_W-1:0]  coef_q;
  logic signed [PW-1:0] prod_q;

  logic [DIV_W-1:0] delta, mag;
  logic             near;
  logic [LIM_W:0]   trial, trial_sub;
  logic             ge;
  logic [G_W-1:0]   step_new, ramp_new, cur_new;
  logic [DIV_W-1:0] d_smooth;
  logic [34:0]      sm_mag;
  logic [35:0]      sm_sum;
  logic [20:0]      sm_rm, sm_r;
  logic [47:0]      num;
  logic signed [34:0] cprod;
  logic [34:0]      cmag;
  logic [35:0]      csum;
  logic [29:0]      crm;

  always_comb begin
    delta = {cur_q[G_W-1], cur_q} - {2'b00, desired_q};
    mag   = delta[DIV_W-1] ? (DIV_W'(0) - delta) : delta;
    near  = mag <= NEAR_LIMIT;

    trial     = {dr_q, dq_q[DIV_W-1]};
    ge        = trial >= {1'b0, lim_i};
    trial_sub = trial - {1'b0, lim_i};

    if (dq_q == '0) begin
      step_new = dpos_q ? '1 : G_W'(1);
    end else if (dpos_q) begin
      step_new = (dq_q > {1'b0, G_MIN}) ? G_MIN : G_W'(DIV_W'(0) - dq_q);
    end else begin
      step_new = (dq_q > {1'b0, G_MAX}) ? G_MAX : dq_q[G_W-1:0];
    end

    ramp_new = sat18({{3{ramp_q[G_W-1]}}, ramp_q} + {{3{step_q[G_W-1]}}, step_q});
    d_smooth = {cur_q[G_W-1], cur_q} - {ramp_q[G_W-1], ramp_q};

    sm_mag  = sm_q[34] ? (35'd0 - sm_q) : sm_q;
    sm_sum  = {1'b0, sm_mag} + 36'd16384;
    sm_rm   = sm_sum[35:15];
    sm_r    = sm_q[34] ? (21'd0 - sm_rm) : sm_rm;
    cur_new = sat18({{3{ramp_q[G_W-1]}}, ramp_q} + sm_r);

    num = {1'b0, ax_q, 15'd0} - {2'b00, bq_q} + 48'h0000_4000_0000;

    cprod = $signed(cur_q) * $signed({1'b0, master_i});
    cmag  = cprod[34] ? (35'd0 - cprod) : cprod;
    csum  = {1'b0, cmag} + 36'd32;
    crm   = csum[35:6];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q     <= {1'b0, RST_GAIN};
      ramp_q    <= {1'b0, RST_GAIN};
      desired_q <= RST_GAIN;
      step_q    <= '0;
      far_q     <= 1'b0;
      dpos_q    <= 1'b0;
    end else begin
      if (ctrl_i.tgt_fin) begin
        desired_q <= num[47:31];
      end
      if (ctrl_i.check) begin
        if (near) begin
          cur_q  <= {1'b0, desired_q};
          ramp_q <= {1'b0, desired_q};
          step_q <= '0;
          far_q  <= 1'b0;
        end else begin
          far_q  <= 1'b1;
          dpos_q <= ~delta[DIV_W-1];
        end
      end
      if (ctrl_i.div_fin && far_q) begin
        step_q <= step_new;
      end
      if (ctrl_i.ramp_add && step_q != '0) begin
        ramp_q <= ramp_new;
      end
      if (ctrl_i.ramp_upd && step_q != '0) begin
        cur_q <= cur_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.tgt_sq) begin
      sq_q <= x_i * x_i;
      ax_q <= x_i * PAN_A;
    end
    if (ctrl_i.tgt_mul) begin
      bq_q <= sq_q * PAN_K;
    end
    if (ctrl_i.check) begin
      dq_q <= mag;
      dr_q <= '0;
    end
    if (ctrl_i.div_step) begin
      dr_q <= ge ? trial_sub[LIM_W-1:0] : trial[LIM_W-1:0];
      dq_q <= {dq_q[DIV_W-2:0], ge};
    end
    if (ctrl_i.ramp_mul) begin
      sm_q <= $signed(d_smooth) * $signed({1'b0, SMOOTH_Q15});
    end
    if (ctrl_i.coef) begin
      coef_q <= cprod[34] ? COEF_W'(30'd0 - crm) : COEF_W'(crm);
    end
    if (ctrl_i.prod) begin
      prod_q <= sample_i * $signed(coef_q);
    end
  end

  assign prod_o = prod_q;

endmodule

// ===== hw/rtl/sep_merge.sv =====
module sep_merge #(
  parameter int SAMPLE_BITS = sep_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   load_i,
  input  logic [SAMPLE_BITS+sep_pkg::COEF_W-1:0] prod_i [sep_pkg::NUM_PATHS],
  output logic                                   free_o,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // left_out, right_out
  output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     m_axis_tdata
);
  import sep_pkg::*;

  localparam int PW  = SAMPLE_BITS + COEF_W;
  localparam int SW2 = PW + 2;
  localparam int RW  = PW - 22;
  localparam int TDW = ((2 * SAMPLE_BITS + 7) / 8) * 8;

  logic                   valid_q;
  logic [SAMPLE_BITS-1:0] left_q, right_q;
  logic [SAMPLE_BITS-1:0] left_mix, right_mix;

  function automatic logic [SAMPLE_BITS-1:0] mix(input logic [PW-1:0] a,
                                                  input logic [PW-1:0] b);
    logic [PW:0]    s;
    logic [PW:0]    mg;
    logic [SW2-1:0] sm;
    logic [RW-1:0]  rm;
    logic [RW-1:0]  v;
    logic           fits;
    s    = {a[PW-1], a} + {b[PW-1], b};
    mg   = s[PW] ? ((PW+1)'(0) - s) : s;
    sm   = {1'b0, mg} + (SW2'(1) << 23);
    rm   = sm[SW2-1:24];
    v    = s[PW] ? (RW'(0) - rm) : rm;
    fits = (&v[RW-1:SAMPLE_BITS-1]) | ~(|v[RW-1:SAMPLE_BITS-1]);
    if (fits) begin
      return v[SAMPLE_BITS-1:0];
    end else if (v[RW-1]) begin
      return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  endfunction

  always_comb begin
    left_mix  = mix(prod_i[0], prod_i[2]);
    right_mix = mix(prod_i[1], prod_i[3]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      left_q  <= left_mix;
      right_q <= right_mix;
    end
  end

  assign free_o        = ~valid_q | m_axis_tready;
  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = TDW'({right_q, left_q});

endmodule

// ===== hw/rtl/stereo_equal_power_panner.sv =====
// Stereo panner with equal-power law and per-block gain ramp.
// Input stream: one transaction carries a left and a right sample; output
// stream: one transaction carries the mixed left and right sample.
// Config channel: index 0 pan position, 1 stereo width, 2 master gain,
// 3 frames per block. A pan or width write recomputes the four target gains
// in four lanes, holding cfg_ready_o and s_axis_tready low through the
// target states (position, square, multiply, finish). Per sample, the one
// shared controller runs coefficient, product, merge and idle;
// inside the ramp window it first runs ramp add, smoothing multiply, update;
// at a block start it first runs the ramp check and a 19 step restoring
// divide. A new sample is taken only in idle, after the last one is merged.
// The output register frees the input side: a new sample is taken while the
// last result waits. If the receiver stalls, the next result holds in the
// merge stage and the controller waits there.
// Reset: control and configuration registers take their default values,
// gains go to straight through, block index returns to zero.
module stereo_equal_power_panner #(
  parameter int RAMP_FRAMES = sep_pkg::DEF_RAMP_FRAMES,
  parameter int SAMPLE_BITS = sep_pkg::DEF_SAMPLE_BITS,
  parameter int MAX_BLOCK   = sep_pkg::DEF_MAX_BLOCK
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // left_sample, right_sample
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]    s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // left_out, right_out
  output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]    m_axis_tdata,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [sep_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [sep_pkg::CFG_DATA_W-1:0]        cfg_data_i
);
  import sep_pkg::*;

  localparam int PW    = SAMPLE_BITS + COEF_W;
  localparam int LIM_W = $clog2(RAMP_FRAMES + 1);
  localparam int IW    = $clog2(MAX_BLOCK);
  localparam int BW    = $clog2(MAX_BLOCK + 1);
  localparam int BXW   = (BW > FPB_W) ? BW : FPB_W;

  state_e               state_q, state_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [IW-1:0]        idx_q, idx_d;
  logic [15:0]          pan_q, gain_q;
  logic [16:0]          width_q;
  logic [FPB_W-1:0]     fpb_q;
  logic [15:0]          p0_q, p1_q;
  logic [SAMPLE_BITS-1:0] left_q, right_q;

  lane_ctrl_t           ctrl;
  logic                 merge_ld, merge_free;
  logic                 in_acc, cfg_acc;
  logic [BXW-1:0]       fpb_x, blk_x;
  logic [BW-1:0]        blk, idx_nxt;
  logic [LIM_W-1:0]     lim;
  logic [IW-1:0]        idx_eff;
  logic [17:0]          aw, lo, hi;
  logic [16:0]          half;
  logic [15:0]          lane_x [NUM_PATHS];
  logic [PW-1:0]        lane_p [NUM_PATHS];

  assign in_acc  = s_axis_tvalid & s_axis_tready;
  assign cfg_acc = cfg_valid_i & cfg_ready_o;

  always_comb begin
    fpb_x = BXW'(fpb_q);
    if (fpb_x == '0) begin
      blk_x = BXW'(1);
    end else if (fpb_x > BXW'(MAX_BLOCK)) begin
      blk_x = BXW'(MAX_BLOCK);
    end else begin
      blk_x = fpb_x;
    end
    blk     = BW'(blk_x);
    lim     = (int'(blk) < RAMP_FRAMES) ? LIM_W'(blk) : LIM_W'(RAMP_FRAMES);
    idx_eff = (BW'(idx_q) >= blk) ? '0 : idx_q;
    idx_nxt = BW'(idx_q) + BW'(1);

    aw   = width_q[16] ? (18'd0 - {1'b1, width_q}) : {1'b0, width_q};
    half = aw[17:1];
    lo   = {2'b00, pan_q} - {1'b0, half};
    hi   = {2'b00, pan_q} + {1'b0, half};

    lane_x[0] = 16'(UNITY_Q15 - {1'b0, p0_q});
    lane_x[1] = p0_q;
    lane_x[2] = 16'(UNITY_Q15 - {1'b0, p1_q});
    lane_x[3] = p1_q;
  end

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    idx_d         = idx_q;
    ctrl          = '0;
    merge_ld      = 1'b0;
    s_axis_tready = 1'b0;
    cfg_ready_o   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        cfg_ready_o   = 1'b1;
        s_axis_tready = ~cfg_valid_i;
        if (cfg_valid_i) begin
          if (cfg_index_i == REG_PAN || cfg_index_i == REG_WIDTH) begin
            state_d = ST_TGT_POS;
          end
        end else if (s_axis_tvalid) begin
          idx_d = idx_eff;
          if (idx_eff == '0) begin
            state_d = ST_CHECK;
          end else if (int'(idx_eff) < int'(lim)) begin
            state_d = ST_RAMP_ADD;
          end else begin
            state_d = ST_COEF;
          end
        end
      end
      ST_TGT_POS: state_d = ST_TGT_SQ;
      ST_TGT_SQ: begin
        ctrl.tgt_sq = 1'b1;
        state_d     = ST_TGT_MUL;
      end
      ST_TGT_MUL: begin
        ctrl.tgt_mul = 1'b1;
        state_d      = ST_TGT_FIN;
      end
      ST_TGT_FIN: begin
        ctrl.tgt_fin = 1'b1;
        state_d      = ST_IDLE;
      end
      ST_CHECK: begin
        ctrl.check = 1'b1;
        cnt_d      = '0;
        state_d    = ST_DIV;
      end
      ST_DIV: begin
        ctrl.div_step = 1'b1;
        cnt_d         = cnt_q + DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
          state_d = ST_DIV_FIN;
        end
      end
      ST_DIV_FIN: begin
        ctrl.div_fin = 1'b1;
        state_d      = ST_RAMP_ADD;
      end
      ST_RAMP_ADD: begin
        ctrl.ramp_add = 1'b1;
        state_d       = ST_RAMP_MUL;
      end
      ST_RAMP_MUL: begin
        ctrl.ramp_mul = 1'b1;
        state_d       = ST_RAMP_UPD;
      end
      ST_RAMP_UPD: begin
        ctrl.ramp_upd = 1'b1;
        state_d       = ST_COEF;
      end
      ST_COEF: begin
        ctrl.coef = 1'b1;
        state_d   = ST_PROD;
      end
      ST_PROD: begin
        ctrl.prod = 1'b1;
        state_d   = ST_MERGE;
      end
      ST_MERGE: begin
        if (merge_free) begin
          merge_ld = 1'b1;
          idx_d    = (idx_nxt >= blk) ? '0 : IW'(idx_nxt);
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      idx_q   <= '0;
      pan_q   <= 16'd16384;
      width_q <= 17'd32768;
      gain_q  <= 16'd32768;
      fpb_q   <= FPB_W'(256);
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      if (cfg_acc) begin
        case (cfg_index_i)
          REG_PAN:    pan_q   <= cfg_data_i[15:0];
          REG_WIDTH:  width_q <= cfg_data_i;
          REG_GAIN:   gain_q  <= cfg_data_i[15:0];
          REG_FRAMES: fpb_q   <= cfg_data_i[FPB_W-1:0];
          default:    ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      left_q  <= s_axis_tdata[SAMPLE_BITS-1:0];
      right_q <= s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
    end
    if (state_q == ST_TGT_POS) begin
      p0_q <= clamp_lane(lo);
      p1_q <= clamp_lane(hi);
    end
  end

  for (genvar g = 0; g < NUM_PATHS; g++) begin : g_lane
    sep_lane #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .LIM_W       (LIM_W),
      .IS_DIAG     ((g == 0) || (g == 3))
    ) u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .x_i      (lane_x[g]),
      .master_i (gain_q),
      .lim_i    (lim),
      .sample_i ((g < 2) ? $signed(left_q) : $signed(right_q)),
      .prod_o   (lane_p[g])
    );
  end

  sep_merge #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (merge_ld),
    .prod_i        (lane_p),
    .free_o        (merge_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  a_cfg_in_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_acc && cfg_acc))
    else $error("config and sample transaction in the same cycle");

  a_tgt_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_acc && (cfg_index_i == REG_PAN || cfg_index_i == REG_WIDTH)
      |=> state_q == ST_TGT_POS)
    else $error("target update did not start after pan or width write");

  a_item_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == ST_CHECK || state_q == ST_RAMP_ADD || state_q == ST_COEF)
    else $error("sample transaction did not start processing");

  a_merge_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    merge_ld |-> (!m_axis_tvalid || m_axis_tready))
    else $error("merge loaded over an untaken result");

endmodule

// ===== dv/pan_mix_checker.sv =====
module pan_mix_checker
  import sep_pkg::*;
#(
  parameter int SB     = DEF_SAMPLE_BITS,
  parameter int DATA_W = ((2*DEF_SAMPLE_BITS+7)/8)*8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [DATA_W-1:0]     s_axis_tdata,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [DATA_W-1:0]     m_axis_tdata,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    mismatch_count_o,
  output int                    samples_in_flight_o
);

  localparam longint unsigned LAW_K = 54512;
  localparam longint SMOOTH    = 29491;
  localparam int     NEAR_MAG  = 65;
  localparam int     RAMP_LEN  = DEF_RAMP_FRAMES;
  localparam int     BLOCK_MAX = DEF_MAX_BLOCK;
  localparam int     UNITY     = 32768;

  typedef struct packed {
    logic [SB-1:0] left;
    logic [SB-1:0] right;
  } mix_pair_t;

  int pan_q15;
  int width_q15;
  int master_q15;
  int frames_cfg;
  int cur_gain [4];
  int ramp_gain [4];
  int tgt_gain [4];
  int ramp_step [4];
  int blk_pos;

  mix_pair_t mix_expected_q [$];

  function automatic int clip18(longint v);
    if (v > 131071) return 131071;
    if (v < -131072) return -131072;
    return int'(v);
  endfunction

  function automatic longint round_shift(longint v, int s);
    longint half;
    half = longint'(1) << (s - 1);
    if (v >= 0) return (v + half) >>> s;
    return -((-v + half) >>> s);
  endfunction

  function automatic int lane_clamp(int x);
    if (x < 0) return 0;
    if (x > UNITY) return UNITY;
    return x;
  endfunction

  function automatic int law_gain(int x);
    longint unsigned ux, a, b;
    ux = longint'(lane_clamp(x));
    a = ux * (65536 + LAW_K) * 32768;
    b = LAW_K * ux * ux;
    return int'((a - b + (64'd1 << 30)) >> 31);
  endfunction

  function automatic void retarget();
    int mag, half_w, lane_l, lane_r;
    mag = width_q15 < 0 ? -width_q15 : width_q15;
    half_w = mag >>> 1;
    lane_l = lane_clamp(pan_q15 - half_w);
    lane_r = lane_clamp(pan_q15 + half_w);
    tgt_gain[0] = law_gain(UNITY - lane_l);
    tgt_gain[1] = law_gain(lane_l);
    tgt_gain[2] = law_gain(UNITY - lane_r);
    tgt_gain[3] = law_gain(lane_r);
  endfunction

  function automatic logic [SB-1:0] clip_sample(longint v);
    longint hi, lo;
    hi = (longint'(1) <<< (SB - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) v = hi;
    else if (v < lo) v = lo;
    return SB'(v);
  endfunction

  function automatic mix_pair_t mix_sample(longint l, longint r);
    int blen, rlen, delta, mag, st;
    longint d;
    longint coef [4];
    mix_pair_t res;
    blen = frames_cfg == 0 ? 1 : (frames_cfg > BLOCK_MAX ? BLOCK_MAX : frames_cfg);
    rlen = blen < RAMP_LEN ? blen : RAMP_LEN;
    if (blk_pos >= blen) blk_pos = 0;
    if (blk_pos == 0) begin
      for (int k = 0; k < 4; k++) begin
        delta = cur_gain[k] - tgt_gain[k];
        mag = delta < 0 ? -delta : delta;
        if (mag > NEAR_MAG) begin
          st = clip18(longint'(-delta) / longint'(rlen));
          if (st == 0) st = delta > 0 ? -1 : 1;
          ramp_step[k] = st;
        end else begin
          cur_gain[k] = tgt_gain[k];
          ramp_gain[k] = tgt_gain[k];
          ramp_step[k] = 0;
        end
      end
    end
    if (blk_pos < rlen) begin
      for (int k = 0; k < 4; k++) begin
        if (ramp_step[k] != 0) begin
          ramp_gain[k] = clip18(longint'(ramp_gain[k]) + ramp_step[k]);
          d = longint'(cur_gain[k]) - ramp_gain[k];
          cur_gain[k] = clip18(longint'(ramp_gain[k]) + round_shift(d * SMOOTH, 15));
        end
      end
    end
    for (int k = 0; k < 4; k++) begin
      coef[k] = round_shift(longint'(cur_gain[k]) * master_q15, 6);
    end
    res.left  = clip_sample(round_shift(l * coef[0] + r * coef[2], 24));
    res.right = clip_sample(round_shift(l * coef[1] + r * coef[3], 24));
    blk_pos++;
    if (blk_pos >= blen) blk_pos = 0;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    int moved;
    mix_pair_t want;
    if (!rst_ni) begin
      pan_q15 = 16384;
      width_q15 = 32768;
      master_q15 = 32768;
      frames_cfg = 256;
      for (int k = 0; k < 4; k++) begin
        cur_gain[k] = (k == 0 || k == 3) ? UNITY : 0;
        ramp_gain[k] = cur_gain[k];
        tgt_gain[k] = cur_gain[k];
        ramp_step[k] = 0;
      end
      blk_pos = 0;
      mix_expected_q.delete();
      mismatch_count_o = 0;
      samples_in_flight_o <= 0;
    end else begin
      moved = 0;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_PAN: begin
            pan_q15 = int'(cfg_data_i[15:0]);
            retarget();
          end
          REG_WIDTH: begin
            width_q15 = $signed(cfg_data_i);
            retarget();
          end
          REG_GAIN: begin
            master_q15 = int'(cfg_data_i[15:0]);
          end
          REG_FRAMES: begin
            frames_cfg = int'(cfg_data_i[FPB_W-1:0]);
          end
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        mix_expected_q.push_back(mix_sample(longint'($signed(s_axis_tdata[SB-1:0])),
                                            longint'($signed(s_axis_tdata[2*SB-1:SB]))));
        moved++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (mix_expected_q.size() == 0) begin
          $display("%0t: output transaction with nothing pending, expected none, got %h",
                   $time, m_axis_tdata);
          mismatch_count_o++;
        end else begin
          want = mix_expected_q.pop_front();
          moved--;
          if (m_axis_tdata[SB-1:0] !== want.left) begin
            $display("%0t: left_out expected %0d, got %0d", $time,
                     $signed(want.left), $signed(m_axis_tdata[SB-1:0]));
            mismatch_count_o++;
          end
          if (m_axis_tdata[2*SB-1:SB] !== want.right) begin
            $display("%0t: right_out expected %0d, got %0d", $time,
                     $signed(want.right), $signed(m_axis_tdata[2*SB-1:SB]));
            mismatch_count_o++;
          end
        end
      end
      samples_in_flight_o <= samples_in_flight_o + moved;
    end
  end

endmodule

// ===== dv/testbench.sv =====
module testbench;
  import sep_pkg::*;

  localparam int SB          = DEF_SAMPLE_BITS;
  localparam int DATA_W      = ((2*SB+7)/8)*8;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_GOAL = 400;
  localparam logic [SB-1:0] S_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic [SB-1:0] S_MIN = {1'b1, {(SB-1){1'b0}}};
  localparam bit [3:0] ALL_REGS = 4'hF;

  typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [DATA_W-1:0]     s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [DATA_W-1:0]     m_axis_tdata;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  int mismatches;
  int in_flight;
  bit hold_req = 1'b0;
  int gap_max = 0;
  int burst_left = 0;
  int samples_sent = 0;

  stereo_equal_power_panner uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  pan_mix_checker mix_chk (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .s_axis_tvalid       (s_axis_tvalid),
    .s_axis_tready       (s_axis_tready),
    .s_axis_tdata        (s_axis_tdata),
    .m_axis_tvalid       (m_axis_tvalid),
    .m_axis_tready       (m_axis_tready),
    .m_axis_tdata        (m_axis_tdata),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .mismatch_count_o    (mismatches),
    .samples_in_flight_o (in_flight)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic program_regs(bit [3:0] mask, int pan, int width, int gain, int frames);
    logic [CFG_DATA_W-1:0] val [4];
    cfg_reg_e r;
    val[REG_PAN]    = CFG_DATA_W'(pan);
    val[REG_WIDTH]  = CFG_DATA_W'(width);
    val[REG_GAIN]   = CFG_DATA_W'(gain);
    val[REG_FRAMES] = CFG_DATA_W'(frames);
    r = r.first();
    repeat (r.num()) begin
      if (mask[r]) begin
        cfg_valid_i <= 1'b1;
        cfg_index_i <= r;
        cfg_data_i  <= val[r];
        @(posedge clk_i);
        while (!cfg_ready_o) @(posedge clk_i);
      end
      r = r.next();
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_sample(logic [SB-1:0] l, logic [SB-1:0] r);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(gap_max, 0);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(16, 1);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= DATA_W'({r, l});
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    samples_sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (in_flight != 0) @(posedge clk_i);
  endtask

  function automatic logic [SB-1:0] rand_sample();
    case ($urandom_range(15, 0))
      0: return S_MAX;
      1: return S_MIN;
      2: return '0;
      default: return SB'($urandom());
    endcase
  endfunction

  // receiver: rotate stall patterns, honor a long hold-off on request
  initial begin
    int cyc;
    rx_mode_e mode;
    cyc = 0;
    mode = RX_OPEN;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      cyc++;
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        if (cyc % 50 == 0) mode = rx_mode_e'($urandom_range(3, 0));
        case (mode)
          RX_OPEN:   m_axis_tready <= 1'b1;
          RX_COIN:   m_axis_tready <= ($urandom_range(1, 0) == 1);
          RX_SPARSE: m_axis_tready <= (cyc % 4 == 0);
          default:   m_axis_tready <= ($urandom_range(7, 0) != 0);
        endcase
      end
    end
  end

  initial begin
    int pan, width, gain, frames, n, phase, goal;
    bit [3:0] mask;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // straight-through gains after reset
    send_sample('0, '0);
    send_sample(S_MAX, S_MAX);
    send_sample(S_MIN, S_MIN);
    send_sample(S_MAX, S_MIN);
    send_sample(S_MIN, S_MAX);
    send_sample(SB'(1), '1);
    drain();

    // hard left, narrow, full gain, one-sample blocks: saturate both paths
    program_regs(ALL_REGS, 0, 0, 65535, 1);
    send_sample(S_MAX, S_MAX);
    send_sample(S_MIN, S_MIN);
    send_sample(S_MAX, S_MIN);
    send_sample(S_MIN, S_MAX);
    drain();

    // hard right, negative width, muted
    program_regs(ALL_REGS, 32768, -32768, 0, 3);
    repeat (3) send_sample(S_MAX, S_MIN);
    drain();

    // pan past hard right, block length zero
    program_regs(ALL_REGS, 65535, 65535, 32768, 0);
    repeat (3) send_sample(rand_sample(), rand_sample());
    drain();

    // widest negative width, oversized block
    program_regs(ALL_REGS, 16384, -65536, 40000, 16383);
    repeat (4) send_sample(S_MAX, S_MAX);
    drain();

    // nudge the pan slightly
    program_regs(4'(1 << REG_PAN), 16414, 0, 0, 0);
    repeat (2) send_sample(S_MIN, S_MAX);
    drain();

    // shrink the block mid-block: index wraps at once
    program_regs(4'(1 << REG_FRAMES), 0, 0, 0, 3);
    repeat (3) send_sample(rand_sample(), rand_sample());
    drain();

    goal = samples_sent + RANDOM_GOAL;
    phase = 0;
    while (samples_sent < goal) begin
      mask = 4'($urandom_range(15, 0));
      case ($urandom_range(15, 0))
        0: pan = 0;
        1: pan = 32768;
        2: pan = $urandom_range(65535, 32769);
        default: pan = $urandom_range(32768, 0);
      endcase
      case ($urandom_range(15, 0))
        0: width = -32768;
        1: width = 32768;
        2: width = 0;
        3: width = $urandom_range(131071, 0);
        default: width = int'($urandom_range(65536, 0)) - 32768;
      endcase
      case ($urandom_range(7, 0))
        0: gain = 0;
        1: gain = 65535;
        2: gain = 32768;
        default: gain = $urandom_range(65535, 0);
      endcase
      case ($urandom_range(9, 0))
        0: frames = 0;
        1: frames = 16383;
        2: frames = 8192;
        3: frames = $urandom_range(16383, 0);
        default: frames = $urandom_range(80, 1);
      endcase
      n = $urandom_range(40, 5);
      gap_max = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
      program_regs(mask, pan, width, gain, frames);
      if (phase == 2) begin
        hold_req = 1'b1;
        gap_max = 0;
        n = 30;
      end
      repeat (n) send_sample(rand_sample(), rand_sample());
      drain();
      phase++;
    end

    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && in_flight == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
